// ===== src/ssd_pkg.sv =====
// Shared widths, glyph table and byte packing for the seven-segment serial driver.
`timescale 1ns / 1ps

package ssd_pkg;

    // Beat widths on the stream ports
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;
    localparam int WORD_W   = 16;
    localparam int CNT_W    = $clog2(WORD_W);
    localparam int GLYPH_N  = 36;

    // Character ranges shown on the display
    localparam logic [7:0] CHAR_DIGIT_LO = 8'd48;
    localparam logic [7:0] CHAR_DIGIT_HI = 8'd57;
    localparam logic [7:0] CHAR_ALPHA_LO = 8'd97;
    localparam logic [7:0] CHAR_ALPHA_HI = 8'd122;
    localparam logic [5:0] DIGIT_BASE    = 6'(CHAR_DIGIT_LO);
    // Letters start at table index 10, so 'a' (97) maps through 87
    localparam logic [5:0] ALPHA_BASE    = 6'(8'd87);

    localparam logic [7:0] POINT_SEG = 8'h01;
    localparam logic [7:0] BLANK     = 8'h00;

    // Segment patterns: digits 0-9, then letters a-z
    localparam logic [7:0] GLYPHS [GLYPH_N] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hE6,
        8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E, 8'hBC, 8'h2E, 8'h60, 8'h70,
        8'hAE, 8'h1C, 8'hEC, 8'h2A, 8'h3A, 8'hCE, 8'hE6, 8'h0A, 8'hB6, 8'h1E,
        8'h7C, 8'h38, 8'h38, 8'h6E, 8'h66, 8'hDA
    };

    // Look up the segment pattern of a character; unmapped codes are blank
    function automatic logic [7:0] glyph_of(input logic [7:0] ch);
        logic [7:0] pat;
        pat = BLANK;
        case (ch) inside
            [CHAR_DIGIT_LO:CHAR_DIGIT_HI]: pat = GLYPHS[ch[5:0] - DIGIT_BASE];
            [CHAR_ALPHA_LO:CHAR_ALPHA_HI]: pat = GLYPHS[ch[5:0] - ALPHA_BASE];
            default:                       pat = BLANK;
        endcase
        return pat;
    endfunction

    // Spread segment and digit-select bits over the two shifted bytes
    function automatic logic [WORD_W-1:0] pack_word(
        input logic [7:0] pix,
        input logic [3:0] dsel
    );
        logic [7:0] first;
        logic [7:0] second;
        first  = {1'b0, pix[7], pix[4], pix[5], pix[0], dsel[3], 2'b00};
        second = {1'b0, pix[1], pix[6], pix[3], pix[2], dsel[1], dsel[0], dsel[2]};
        return {second, first};
    endfunction

endpackage

// ===== src/seven_segment_serial_driver.sv =====
// Top level: turns a character beat into sixteen inverted serial bits for a shift-register display.
`timescale 1ns / 1ps

// Each accepted beat (digit select, character, dot, enable) is looked up in a
// glyph table, packed into two bytes and sent out as sixteen output beats, one
// bit each, first byte then second, LSB first, every bit inverted. tlast marks
// the sixteenth bit, after which the display latch should pulse. The shifter
// sends one bit per output beat; a second item is held in an input register
// while the shifter runs, so with the output always ready the bit stream
// continues without gaps between characters.
module seven_segment_serial_driver
(
    input  logic                         clk,
    input  logic                         rst_n,
    // [3:0] digit_select, [11:4] ascii_char, [12] dot_on, [13] display_enable
    input  logic [ssd_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [0] serial_data
    output logic [ssd_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready
);
    import ssd_pkg::*;

    logic [3:0]        digit_select;
    logic [7:0]        ascii_char;
    logic              dot_on;
    logic              display_enable;
    logic [7:0]        pix;

    logic [WORD_W-1:0] pend_word_reg, pend_word_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;

    logic              s_fire;
    logic              m_fire;
    logic              last_bit;
    logic              load;

    // Unpack the input beat
    assign digit_select   = s_tdata[3:0];
    assign ascii_char     = s_tdata[11:4];
    assign dot_on         = s_tdata[12];
    assign display_enable = s_tdata[13];

    // Blank when disabled, else glyph with the dot ORed in
    always_comb
    begin
        pix = BLANK;
        if (display_enable)
        begin
            pix = glyph_of(ascii_char);
            if (dot_on)
            begin
                pix = pix | POINT_SEG;
            end
        end
    end

    assign last_bit = (cnt_reg == CNT_W'(WORD_W - 1));
    assign m_fire   = m_tvalid && m_tready;
    // Shifter takes the held word when idle or when its last bit goes out
    assign load     = pend_valid_reg && (!busy_reg || (m_fire && last_bit));
    assign s_tready = !pend_valid_reg || load;
    assign s_fire   = s_tvalid && s_tready;

    // Hold the next word while the shifter is busy
    always_comb
    begin
        pend_word_next  = pend_word_reg;
        pend_valid_next = pend_valid_reg;
        if (load)
        begin
            pend_valid_next = 1'b0;
        end
        if (s_fire)
        begin
            pend_word_next  = pack_word(pix, digit_select);
            pend_valid_next = 1'b1;
        end
    end

    // Advance the shifter one bit per output beat
    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (load)
        begin
            shift_next = pend_word_reg;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (m_fire)
        begin
            if (last_bit)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                shift_next = {1'b0, shift_reg[WORD_W-1:1]};
                cnt_next   = cnt_reg + CNT_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            busy_reg       <= busy_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pend_word_reg <= pend_word_next;
        shift_reg     <= shift_next;
    end

    // Drive the inverted bit
    assign m_tvalid = busy_reg;
    assign m_tdata  = {{(M_DATA_W-1){1'b0}}, ~shift_reg[0]};
    assign m_tlast  = last_bit;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the seven-segment serial driver.
`timescale 1ns / 1ps

module testbench;

    import ssd_pkg::S_DATA_W;
    import ssd_pkg::M_DATA_W;

    // One expected output beat: the inverted data bit and the latch marker
    typedef struct packed {
        logic level;
        logic latch;
    } shift_bit_t;

    // Segment patterns for '0'-'9' then 'a'-'z'
    localparam logic [7:0] SEG_ROM [36] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hE6,
        8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E, 8'hBC, 8'h2E, 8'h60, 8'h70,
        8'hAE, 8'h1C, 8'hEC, 8'h2A, 8'h3A, 8'hCE, 8'hE6, 8'h0A, 8'hB6, 8'h1E,
        8'h7C, 8'h38, 8'h38, 8'h6E, 8'h66, 8'hDA
    };

    localparam int BITS_PER_CHAR = 16;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int SETTLE_CYCLES = 40;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    // [3:0] digit_select, [11:4] ascii_char, [12] dot_on, [13] display_enable
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // [0] serial_data
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    shift_bit_t pending_bits [$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         chars_sent = 0;
    int         bits_checked = 0;
    int         mismatches = 0;
    int         blank_chars = 0;
    int         dark_chars = 0;

    seven_segment_serial_driver i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Free-running 100 MHz clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the stream hangs
    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    // Look up the lit segments for a character; anything unmapped is dark
    function automatic logic [7:0] segments_for(input logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39)
            return SEG_ROM[int'(ch) - 48];
        if (ch >= 8'h61 && ch <= 8'h7A)
            return SEG_ROM[int'(ch) - 87];
        return 8'h00;
    endfunction

    // Build the 16-bit shift word: first byte in [7:0], second in [15:8]
    function automatic logic [15:0] shift_word_for(input logic [S_DATA_W-1:0] beat);
        logic [3:0]  dsel;
        logic [7:0]  pix;
        logic [15:0] w;
        dsel = beat[3:0];
        pix  = 8'h00;
        if (beat[13])
            pix = segments_for(beat[11:4]) | {7'b0, beat[12]};
        w     = '0;
        w[6]  = pix[7];
        w[4]  = pix[5];
        w[5]  = pix[4];
        w[3]  = pix[0];
        w[2]  = dsel[3];
        w[13] = pix[6];
        w[12] = pix[3];
        w[11] = pix[2];
        w[14] = pix[1];
        w[9]  = dsel[0];
        w[10] = dsel[1];
        w[8]  = dsel[2];
        return w;
    endfunction

    // Queue the sixteen inverted bits an accepted character will produce
    task automatic queue_char_bits(input logic [S_DATA_W-1:0] beat);
        logic [15:0] w;
        shift_bit_t  b;
        w = shift_word_for(beat);
        for (int i = 0; i < BITS_PER_CHAR; i++)
        begin
            b.level = ~w[i];
            b.latch = (i == BITS_PER_CHAR - 1);
            pending_bits.push_back(b);
        end
        chars_sent++;
        if (beat[13] && segments_for(beat[11:4]) == 8'h00)
            blank_chars++;
        if (!beat[13])
            dark_chars++;
    endtask

    // Predict on input beats, then compare each output beat with the oldest bit
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                queue_char_bits(s_tdata);
            if (m_tvalid && m_tready)
            begin
                shift_bit_t want;
                if (pending_bits.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected output beat, expected none, actual data=%0h last=%0b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = pending_bits.pop_front();
                    bits_checked++;
                    if (m_tdata[0] !== want.level)
                    begin
                        mismatches++;
                        $display("%0t: serial_data mismatch, expected %0b, actual %0b",
                                 $time, want.level, m_tdata[0]);
                    end
                    if (m_tdata[M_DATA_W-1:1] !== '0)
                    begin
                        mismatches++;
                        $display("%0t: tdata padding mismatch, expected 0, actual %0h",
                                 $time, m_tdata[M_DATA_W-1:1]);
                    end
                    if (m_tlast !== want.latch)
                    begin
                        mismatches++;
                        $display("%0t: latch_after mismatch, expected %0b, actual %0b",
                                 $time, want.latch, m_tlast);
                    end
                end
            end
        end
    end

    // Stall the output side at the current rate
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one character beat and hold it until accepted
    task automatic send_char(
        input logic [3:0] dsel,
        input logic [7:0] ch,
        input logic       dot,
        input logic       en
    );
        int gap;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {2'b00, en, dot, ch, dsel};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drop valid and wait for every queued bit to come out
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_bits.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    // Pick a character, biased toward the ones with a glyph
    function automatic logic [7:0] pick_char();
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'($urandom_range(8'h30, 8'h39));
            4, 5, 6, 7: return 8'($urandom_range(8'h61, 8'h7A));
            default:    return 8'($urandom_range(255));
        endcase
    endfunction

    // Field extremes, range borders and the blank, dot and disabled cases
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_char(4'h0, 8'h30, 1'b0, 1'b1);   // '0'
        send_char(4'hF, 8'h39, 1'b1, 1'b1);   // '9' with dot
        send_char(4'h1, 8'h61, 1'b0, 1'b1);   // 'a'
        send_char(4'h2, 8'h7A, 1'b1, 1'b1);   // 'z'
        send_char(4'h4, 8'h2F, 1'b0, 1'b1);   // just below the digits
        send_char(4'h8, 8'h3A, 1'b0, 1'b1);   // just above the digits
        send_char(4'h3, 8'h60, 1'b0, 1'b1);   // just below the letters
        send_char(4'hC, 8'h7B, 1'b0, 1'b1);   // just above the letters
        send_char(4'h5, 8'h41, 1'b0, 1'b1);   // upper case is blank
        send_char(4'hA, 8'h5A, 1'b1, 1'b1);
        send_char(4'h6, 8'h20, 1'b0, 1'b1);   // space
        send_char(4'h9, 8'h20, 1'b1, 1'b1);   // dot alone on a blank char
        send_char(4'h0, 8'h00, 1'b1, 1'b1);
        send_char(4'hF, 8'hFF, 1'b0, 1'b1);
        send_char(4'h7, 8'h38, 1'b1, 1'b0);   // disabled: dot ignored
        send_char(4'hF, 8'hFF, 1'b1, 1'b0);
        send_char(4'h0, 8'h80, 1'b0, 1'b1);
        send_char(4'hB, 8'h6D, 1'b1, 1'b1);   // 'm'
        wait_drained();
    endtask

    // Random characters at the given idle and stall rates
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
            send_char(4'($urandom_range(15)), pick_char(), 1'($urandom_range(1)),
                      ($urandom_range(9) != 0));
    endtask

    // Pause the sender until the stream is empty, then resume back to back
    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        for (int n = 0; n < 4; n++)
            send_char(4'($urandom_range(15)), pick_char(), 1'($urandom_range(1)), 1'b1);
        wait_drained();
        for (int n = 0; n < 4; n++)
            send_char(4'($urandom_range(15)), pick_char(), 1'($urandom_range(1)), 1'b1);
    endtask

    // Run the test sequence and report
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(100, 22, 54);
        test_random(100, 54, 22);
        test_random(90, 0, 0);
        test_drain_pause();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_bits.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected bits never arrived", $time, pending_bits.size());
        end

        $display("Sent %0d characters (%0d blank glyphs, %0d with display off), %0d bits checked.",
                 chars_sent, blank_chars, dark_chars, bits_checked);
        $display("Idling covered sender-heavy, receiver-heavy and gap-free stretches.");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
